FILE: design/spbp_pkg.sv
// Shared types, constants and helper functions for the SNMP PDU BER parser.
`default_nettype none

package spbp_pkg;

   // Command codes on the input channel.
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Result kinds.
   localparam logic [2:0] KIND_REQ_ID     = 3'd0;
   localparam logic [2:0] KIND_ERR_STATUS = 3'd1;
   localparam logic [2:0] KIND_ERR_INDEX  = 3'd2;
   localparam logic [2:0] KIND_OID_BYTE   = 3'd3;
   localparam logic [2:0] KIND_VALUE_BYTE = 3'd4;
   localparam logic [2:0] KIND_EMPTY      = 3'd5;
   localparam logic [2:0] KIND_LIST_END   = 3'd6;
   localparam logic [2:0] KIND_ERROR      = 3'd7;

   // Fault codes.
   localparam logic [2:0] FAULT_NONE     = 3'd0;
   localparam logic [2:0] FAULT_MISSING  = 3'd1;
   localparam logic [2:0] FAULT_TAG      = 3'd2;
   localparam logic [2:0] FAULT_OVERRUN  = 3'd3;
   localparam logic [2:0] FAULT_VB_LEN   = 3'd4;
   localparam logic [2:0] FAULT_PDU_LEN  = 3'd5;
   localparam logic [2:0] FAULT_COUNT    = 3'd6;
   localparam logic [2:0] FAULT_LEN_LONG = 3'd7;

   // BER tags and length encoding.
   localparam logic [7:0] TAG_INT       = 8'h02;
   localparam logic [7:0] TAG_OID       = 8'h06;
   localparam logic [7:0] TAG_SEQ       = 8'h30;
   localparam logic [6:0] MAX_LEN_BYTES = 7'd4;

   // Largest number of varbinds in one list.
   localparam logic [7:0] MAX_BINDINGS = 8'd16;

   // Number of integers ahead of the varbind list.
   localparam logic [7:0] NUM_HEADER_INTS = 8'd3;

   typedef struct packed {
      logic        have;
      logic [2:0]  kind;
      logic [31:0] ival;
      logic [7:0]  fbyte;
      logic [7:0]  vtag;
      logic [7:0]  bnum;
      logic        last;
      logic        done;
      logic [2:0]  fault;
   } res_type;

   // Starts a fresh result of the given kind with all other fields cleared.
   function automatic res_type put_res(logic [2:0] kind);
      res_type r;
      r      = '0;
      r.have = 1'b1;
      r.kind = kind;
      return r;
   endfunction

   // Adds a fault code; a result that does not exist yet becomes an error result.
   function automatic res_type fail_res(res_type r_in, logic [2:0] code);
      res_type r;
      r = r_in;
      if (!r.have) begin
         r = put_res(KIND_ERROR);
      end
      r.fault = code;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/snmp_pdu_ber_parser_top.sv
// Top level of the SNMP PDU BER parser: input register, parse logic, result register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   command, pdu_tag, pdu_length, data_byte
//  rsp      out        rsp_valid/rsp_stall   kind, int_value, field_byte, value_tag,
//                                            binding_number, field_last, pdu_done,
//                                            echo_tag, fault
//
// One item per cycle while rsp is not stalled: each transfer is parsed while it sits
// in the input register, and its result (if any) is then held in the result register.
// The parse state update is one tag compare, one length compare and a few counters.
// Reset is synchronous and clears the parse phase and both valid flags.
// A stall on rsp holds the result register; the input register then holds one
// item and req_stall rises only while that item cannot move on.
`default_nettype none

module snmp_pdu_ber_parser_top
   import spbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_pdu_tag,
   input  wire logic [15:0] req_pdu_length,
   input  wire logic [7:0]  req_data_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_int_value,
   output logic [7:0]       rsp_field_byte,
   output logic [7:0]       rsp_value_tag,
   output logic [7:0]       rsp_binding_number,
   output logic             rsp_field_last,
   output logic             rsp_pdu_done,
   output logic [7:0]       rsp_echo_tag,
   output logic [2:0]       rsp_fault
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_INT_TAG  = 4'd1;
   localparam logic [3:0] PH_INT_LEN  = 4'd2;
   localparam logic [3:0] PH_INT_VAL  = 4'd3;
   localparam logic [3:0] PH_LIST_TAG = 4'd4;
   localparam logic [3:0] PH_LIST_LEN = 4'd5;
   localparam logic [3:0] PH_VB_TAG   = 4'd6;
   localparam logic [3:0] PH_VB_LEN   = 4'd7;
   localparam logic [3:0] PH_OID_TAG  = 4'd8;
   localparam logic [3:0] PH_OID_LEN  = 4'd9;
   localparam logic [3:0] PH_OID_VAL  = 4'd10;
   localparam logic [3:0] PH_VAL_TAG  = 4'd11;
   localparam logic [3:0] PH_VAL_LEN  = 4'd12;
   localparam logic [3:0] PH_VAL_VAL  = 4'd13;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_tag_ff;
   logic [15:0] in_len_ff;
   logic [7:0]  in_byte_ff;

   // Parse state.
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] pdu_left_ff, pdu_left_in;
   logic [15:0] list_left_ff, list_left_in;
   logic [15:0] binding_left_ff, binding_left_in;
   logic [15:0] field_left_ff, field_left_in;
   logic [2:0]  len_bytes_ff, len_bytes_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  cur_tag_ff, cur_tag_in;
   logic [7:0]  bind_count_ff, bind_count_in;
   logic [7:0]  saved_tag_ff, saved_tag_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     res_ff, res_in;

   logic        accept;
   logic        advance;
   logic [15:0] pl_dec, ll_dec, bl_dec, fl_dec;
   logic [15:0] len_bound;
   logic        fin_go;
   logic [31:0] fin_len;
   logic        int_go, valdone_go, list_go, valtag_go;

   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? res_in.have : (rsp_valid_ff && rsp_stall);

   // Byte counts of the enclosing elements after this content byte is counted.
   assign pl_dec = (pdu_left_ff != '0) ? pdu_left_ff - 16'd1 : pdu_left_ff;
   assign ll_dec = (phase_ff >= PH_VB_TAG && list_left_ff != '0) ?
                   list_left_ff - 16'd1 : list_left_ff;
   assign bl_dec = (phase_ff >= PH_OID_TAG && binding_left_ff != '0) ?
                   binding_left_ff - 16'd1 : binding_left_ff;
   assign fl_dec = (field_left_ff != '0) ? field_left_ff - 16'd1 : field_left_ff;

   // A length must fit in the element that encloses it.
   always_comb begin
      if (phase_ff inside {PH_INT_TAG, PH_INT_LEN, PH_LIST_TAG, PH_LIST_LEN}) begin
         len_bound = pl_dec;
      end else if (phase_ff inside {PH_VB_TAG, PH_VB_LEN}) begin
         len_bound = ll_dec;
      end else begin
         len_bound = bl_dec;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      pdu_left_in     = pdu_left_ff;
      list_left_in    = list_left_ff;
      binding_left_in = binding_left_ff;
      field_left_in   = field_left_ff;
      len_bytes_in    = len_bytes_ff;
      acc_in          = acc_ff;
      cur_tag_in      = cur_tag_ff;
      bind_count_in   = bind_count_ff;
      saved_tag_in    = saved_tag_ff;
      res_in          = '0;
      fin_go          = 1'b0;
      fin_len         = '0;
      int_go          = 1'b0;
      valdone_go      = 1'b0;
      list_go         = 1'b0;
      valtag_go       = 1'b0;

      if (advance) begin
         if (in_cmd_ff == CMD_BEGIN) begin
            saved_tag_in    = in_tag_ff;
            pdu_left_in     = in_len_ff;
            list_left_in    = '0;
            binding_left_in = '0;
            field_left_in   = '0;
            len_bytes_in    = '0;
            acc_in          = '0;
            cur_tag_in      = '0;
            bind_count_in   = '0;
            phase_in        = PH_INT_TAG;
            if (in_len_ff == '0) begin
               res_in   = fail_res(res_in, FAULT_MISSING);
               phase_in = PH_IDLE;
            end
         end else if (phase_ff != PH_IDLE) begin
            pdu_left_in     = pl_dec;
            list_left_in    = ll_dec;
            binding_left_in = bl_dec;

            case (phase_ff)
               PH_INT_TAG, PH_LIST_TAG, PH_VB_TAG, PH_OID_TAG, PH_VAL_TAG: begin
                  if (phase_ff == PH_VAL_TAG) begin
                     cur_tag_in = in_byte_ff;
                  end
                  if ((phase_ff == PH_INT_TAG && in_byte_ff != TAG_INT) ||
                      (phase_ff == PH_LIST_TAG && in_byte_ff != TAG_SEQ) ||
                      (phase_ff == PH_VB_TAG && in_byte_ff != TAG_SEQ) ||
                      (phase_ff == PH_OID_TAG && in_byte_ff != TAG_OID)) begin
                     res_in   = fail_res(res_in, FAULT_TAG);
                     phase_in = PH_IDLE;
                  end else if (phase_ff == PH_VB_TAG && bind_count_ff >= MAX_BINDINGS) begin
                     res_in   = fail_res(res_in, FAULT_COUNT);
                     phase_in = PH_IDLE;
                  end else begin
                     // Every tag phase code is one below its length phase code.
                     phase_in     = phase_ff + 4'd1;
                     len_bytes_in = '0;
                     acc_in       = '0;
                     if (len_bound == '0) begin
                        res_in   = fail_res(res_in, FAULT_OVERRUN);
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_INT_LEN, PH_LIST_LEN, PH_VB_LEN, PH_OID_LEN, PH_VAL_LEN: begin
                  if (len_bytes_ff == '0) begin
                     if (in_byte_ff[7]) begin
                        if (in_byte_ff[6:0] > MAX_LEN_BYTES) begin
                           res_in   = fail_res(res_in, FAULT_LEN_LONG);
                           phase_in = PH_IDLE;
                        end else if (in_byte_ff[6:0] == '0) begin
                           fin_go  = 1'b1;
                           fin_len = '0;
                        end else begin
                           len_bytes_in = in_byte_ff[2:0];
                           acc_in       = '0;
                           if (len_bound == '0) begin
                              res_in   = fail_res(res_in, FAULT_OVERRUN);
                              phase_in = PH_IDLE;
                           end
                        end
                     end else begin
                        fin_go  = 1'b1;
                        fin_len = {24'd0, in_byte_ff};
                     end
                  end else begin
                     acc_in       = {acc_ff[23:0], in_byte_ff};
                     len_bytes_in = len_bytes_ff - 3'd1;
                     if (len_bytes_in == '0) begin
                        fin_go  = 1'b1;
                        fin_len = acc_in;
                     end else if (len_bound == '0) begin
                        res_in   = fail_res(res_in, FAULT_OVERRUN);
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_INT_VAL: begin
                  acc_in        = {acc_ff[23:0], in_byte_ff};
                  field_left_in = fl_dec;
                  if (fl_dec == '0) begin
                     int_go = 1'b1;
                  end
               end
               PH_OID_VAL, PH_VAL_VAL: begin
                  res_in       = put_res((phase_ff == PH_VAL_VAL) ? KIND_VALUE_BYTE
                                                                  : KIND_OID_BYTE);
                  res_in.fbyte = in_byte_ff;
                  res_in.bnum  = bind_count_ff;
                  res_in.vtag  = (phase_ff == PH_VAL_VAL) ? cur_tag_ff : 8'd0;
                  field_left_in = fl_dec;
                  if (fl_dec == '0) begin
                     res_in.last = 1'b1;
                     if (phase_ff == PH_VAL_VAL) begin
                        valdone_go = 1'b1;
                     end else begin
                        valtag_go = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase

            // A complete length is checked against its element and acted on.
            if (fin_go) begin
               if (fin_len > {16'd0, len_bound}) begin
                  res_in   = fail_res(res_in, FAULT_OVERRUN);
                  phase_in = PH_IDLE;
               end else begin
                  case (phase_ff)
                     PH_INT_LEN: begin
                        field_left_in = fin_len[15:0];
                        acc_in        = '0;
                        if (fin_len == '0) begin
                           int_go = 1'b1;
                        end else begin
                           phase_in = PH_INT_VAL;
                        end
                     end
                     PH_LIST_LEN: begin
                        list_left_in  = fin_len[15:0];
                        bind_count_in = '0;
                        phase_in      = PH_VB_TAG;
                        if (fin_len == '0) begin
                           list_go = 1'b1;
                        end
                     end
                     PH_VB_LEN: begin
                        binding_left_in = fin_len[15:0];
                        cur_tag_in      = '0;
                        phase_in        = PH_OID_TAG;
                        if (fin_len == '0) begin
                           res_in   = fail_res(res_in, FAULT_MISSING);
                           phase_in = PH_IDLE;
                        end
                     end
                     PH_OID_LEN: begin
                        field_left_in = fin_len[15:0];
                        if (fin_len == '0) begin
                           res_in      = put_res(KIND_EMPTY);
                           res_in.bnum = bind_count_ff;
                           res_in.last = 1'b1;
                           valtag_go   = 1'b1;
                        end else begin
                           phase_in = PH_OID_VAL;
                        end
                     end
                     default: begin
                        field_left_in = fin_len[15:0];
                        if (fin_len == '0) begin
                           res_in      = put_res(KIND_EMPTY);
                           res_in.bnum = bind_count_ff;
                           res_in.vtag = cur_tag_ff;
                           res_in.last = 1'b1;
                           valdone_go  = 1'b1;
                        end else begin
                           phase_in = PH_VAL_VAL;
                        end
                     end
                  endcase
               end
            end

            // One of the header integers is complete.
            if (int_go) begin
               res_in        = put_res(bind_count_ff[2:0]);
               res_in.ival   = acc_in;
               bind_count_in = bind_count_ff + 8'd1;
               if (bind_count_in >= NUM_HEADER_INTS) begin
                  bind_count_in = '0;
                  phase_in      = PH_LIST_TAG;
               end else begin
                  phase_in = PH_INT_TAG;
               end
               if (pdu_left_in == '0) begin
                  res_in   = fail_res(res_in, FAULT_MISSING);
                  phase_in = PH_IDLE;
               end
            end

            // The value closes the varbind, which must be used up exactly.
            if (valdone_go) begin
               if (binding_left_in != '0) begin
                  res_in   = fail_res(res_in, FAULT_VB_LEN);
                  phase_in = PH_IDLE;
               end else begin
                  bind_count_in = bind_count_ff + 8'd1;
                  phase_in      = PH_VB_TAG;
                  if (list_left_in == '0) begin
                     list_go = 1'b1;
                  end
               end
            end

            // The list has ended; the PDU must end with it.
            if (list_go) begin
               if (!res_in.have) begin
                  res_in = put_res(KIND_LIST_END);
               end
               phase_in = PH_IDLE;
               if (pdu_left_in == '0) begin
                  res_in.done = 1'b1;
               end else begin
                  res_in = fail_res(res_in, FAULT_PDU_LEN);
               end
            end

            if (valtag_go) begin
               phase_in = PH_VAL_TAG;
               if (binding_left_in == '0) begin
                  res_in   = fail_res(res_in, FAULT_MISSING);
                  phase_in = PH_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         pdu_left_ff     <= '0;
         list_left_ff    <= '0;
         binding_left_ff <= '0;
         field_left_ff   <= '0;
         len_bytes_ff    <= '0;
         acc_ff          <= '0;
         cur_tag_ff      <= '0;
         bind_count_ff   <= '0;
         saved_tag_ff    <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         pdu_left_ff     <= pdu_left_in;
         list_left_ff    <= list_left_in;
         binding_left_ff <= binding_left_in;
         field_left_ff   <= field_left_in;
         len_bytes_ff    <= len_bytes_in;
         acc_ff          <= acc_in;
         cur_tag_ff      <= cur_tag_in;
         bind_count_ff   <= bind_count_in;
         saved_tag_ff    <= saved_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_command;
         in_tag_ff  <= req_pdu_tag;
         in_len_ff  <= req_pdu_length;
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = res_ff.kind;
   assign rsp_int_value      = res_ff.ival;
   assign rsp_field_byte     = res_ff.fbyte;
   assign rsp_value_tag      = res_ff.vtag;
   assign rsp_binding_number = res_ff.bnum;
   assign rsp_field_last     = res_ff.last;
   assign rsp_pdu_done       = res_ff.done;
   assign rsp_echo_tag       = saved_tag_ff;
   assign rsp_fault          = res_ff.fault;

   // Data bytes that arrive while idle must not make a result.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      advance && in_cmd_ff == CMD_DATA && phase_ff == PH_IDLE |-> !res_in.have)
      else $error("result produced from a data byte while idle");

   // Any fault leaves the parser idle.
   a_fault_idle: assert property (@(posedge clock) disable iff (reset)
      advance && res_in.fault != FAULT_NONE |=> phase_ff == PH_IDLE)
      else $error("parser not idle after a fault");

   // A completed PDU never carries a fault.
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(res_ff.done && res_ff.fault != FAULT_NONE))
      else $error("pdu_done reported together with a fault");

   // The varbind count stays within the limit while the list is walked.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VB_TAG |-> bind_count_ff <= MAX_BINDINGS)
      else $error("varbind count beyond the limit");

endmodule

`default_nettype wire
